/* hdl/i2d_pkg.sv */
// Shared types and constants of the 64-bit binary to decimal ASCII converter.
`default_nettype none
package i2d_pkg;

	localparam int VALUE_W       = 64;
	localparam int NUM_DIGITS    = 20;
	localparam int DIGIT_W       = 4;
	localparam int BITS_PER_STEP = 4;
	localparam int STEPS         = VALUE_W / BITS_PER_STEP;
	localparam int CHAR_W        = 6;
	localparam int LEN_W         = 5;
	localparam int IDX_W         = $clog2(NUM_DIGITS);

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

	typedef logic [DIGIT_W-1:0] digit_t;

	// Finished conversion handed from the converter to the emitter
	typedef struct packed {
		digit_t [NUM_DIGITS-1:0] digits;
		logic                    negative;
	} conv_res_t;

endpackage
`default_nettype wire

/* hdl/i2d_in_if.sv */
// Input channel: 64-bit value and conversion mode with valid/ready handshake.
`default_nettype none
interface i2d_in_if;
	logic                         valid;
	logic                         ready;
	logic [i2d_pkg::VALUE_W-1:0]  value;
	logic                         mode;

	modport source (output valid, output value, output mode, input ready);
	modport sink   (input valid, input value, input mode, output ready);
endinterface
`default_nettype wire

/* hdl/i2d_out_if.sv */
// Output channel: one ASCII character per transaction with length and last flag.
`default_nettype none
interface i2d_out_if;
	logic                        valid;
	logic                        ready;
	logic [i2d_pkg::CHAR_W-1:0]  character;
	logic [i2d_pkg::LEN_W-1:0]   text_length;
	logic                        last;

	modport source (output valid, output character, output text_length, output last,
		input ready);
	modport sink   (input valid, input character, input text_length, input last,
		output ready);
endinterface
`default_nettype wire

/* hdl/i2d_conv.sv */
// Iterative shift-and-add-3 converter: binary magnitude to 20 BCD digits.
`default_nettype none
module i2d_conv (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [i2d_pkg::VALUE_W-1:0] mag,
	input  wire logic                        negative,
	output logic                             idle,
	output logic                             res_valid,
	input  wire logic                        res_take,
	output i2d_pkg::conv_res_t               res
);

	localparam int CNT_W = $clog2(i2d_pkg::STEPS);
	localparam int BCD_W = i2d_pkg::NUM_DIGITS * i2d_pkg::DIGIT_W;

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [i2d_pkg::VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]            bcd_q;
	logic                        neg_q;
	logic [BCD_W-1:0]            bcd_next;

	// One bit of double dabble: correct digits of five or more, then shift in
	function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
		input logic bit_in);
		logic [BCD_W-1:0] adj;
		logic [i2d_pkg::DIGIT_W-1:0] dig;
		adj = bcd;
		for (int i = 0; i < i2d_pkg::NUM_DIGITS; i++) begin
			dig = bcd[i*i2d_pkg::DIGIT_W +: i2d_pkg::DIGIT_W];
			if (dig >= 4'd5) begin
				adj[i*i2d_pkg::DIGIT_W +: i2d_pkg::DIGIT_W] = dig + 4'd3;
			end
		end
		return {adj[BCD_W-2:0], bit_in};
	endfunction

	// Shared unit applied to the top bits of the operand, most significant first
	always_comb begin
		bcd_next = bcd_q;
		for (int b = 0; b < i2d_pkg::BITS_PER_STEP; b++) begin
			bcd_next = dabble(bcd_next, bin_q[i2d_pkg::VALUE_W-1-b]);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(i2d_pkg::STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (done_q && res_take) begin
				done_q <= 1'b0;
			end
		end
	end

	// Operand and digit registers
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
			neg_q <= negative;
		end else if (busy_q) begin
			bin_q <= {bin_q[i2d_pkg::VALUE_W-i2d_pkg::BITS_PER_STEP-1:0],
				i2d_pkg::BITS_PER_STEP'(0)};
			bcd_q <= bcd_next;
		end
	end

	assign idle          = !busy_q && !done_q;
	assign res_valid     = done_q;
	assign res.digits    = bcd_q;
	assign res.negative  = neg_q;

endmodule
`default_nettype wire

/* hdl/i2d_emit.sv */
// Character emitter: sizes the text and sends sign and digits one per transaction.
`default_nettype none
module i2d_emit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                res_valid,
	output logic                     res_take,
	input  wire i2d_pkg::conv_res_t  res,
	i2d_out_if.source                out_ch
);

	logic                                         active_q;
	logic                                         sign_q;
	logic [i2d_pkg::IDX_W-1:0]                    idx_q;
	logic [i2d_pkg::LEN_W-1:0]                    len_q;
	i2d_pkg::digit_t [i2d_pkg::NUM_DIGITS-1:0]    digits_q;
	logic [i2d_pkg::IDX_W-1:0]                    msd;
	logic                                         fire;

	// Position of the most significant nonzero digit (zero if all digits are zero)
	always_comb begin
		msd = '0;
		for (int i = 0; i < i2d_pkg::NUM_DIGITS; i++) begin
			if (res.digits[i] != '0) begin
				msd = i2d_pkg::IDX_W'(i);
			end
		end
	end

	assign res_take = res_valid && !active_q;
	assign fire     = out_ch.valid && out_ch.ready;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			sign_q   <= 1'b0;
			idx_q    <= '0;
		end else if (res_take) begin
			active_q <= 1'b1;
			sign_q   <= res.negative;
			idx_q    <= msd;
		end else if (fire) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else if (idx_q == '0) begin
				active_q <= 1'b0;
			end else begin
				idx_q <= idx_q - i2d_pkg::IDX_W'(1);
			end
		end
	end

	// Text payload
	always_ff @(posedge clk) begin
		if (res_take) begin
			digits_q <= res.digits;
			len_q    <= i2d_pkg::LEN_W'(msd) + i2d_pkg::LEN_W'(1)
				+ i2d_pkg::LEN_W'(res.negative);
		end
	end

	assign out_ch.valid       = active_q;
	assign out_ch.character   = sign_q ? i2d_pkg::ASCII_MINUS
		: i2d_pkg::ASCII_ZERO + i2d_pkg::CHAR_W'(digits_q[idx_q]);
	assign out_ch.text_length = len_q;
	assign out_ch.last        = !sign_q && (idx_q == '0);

endmodule
`default_nettype wire

/* hdl/int64_to_decimal_ascii.sv */
// Top level: 64-bit signed/unsigned integer to decimal ASCII character stream.
// The accepted value runs through the converter's 16 steps of 4 bits each; the result
// is then handed off into the emitter, which offers the first character.
// Throughput: one character per cycle while out_ch.ready is high; the next value is
// taken while the previous text is sent.
// Reset: arst_n clears all handshake and sequencer state; no text is pending.
`default_nettype none
module int64_to_decimal_ascii (
	input  wire logic  clk,
	input  wire logic  arst_n,
	i2d_in_if.sink     in_ch,
	i2d_out_if.source  out_ch
);

	logic                        conv_idle;
	logic                        start;
	logic                        negative;
	logic [i2d_pkg::VALUE_W-1:0] mag;
	logic                        res_valid;
	logic                        res_take;
	i2d_pkg::conv_res_t          res;

	// Accept a new transaction whenever the converter is free
	assign in_ch.ready = conv_idle;
	assign start       = in_ch.valid && in_ch.ready;

	// Sign handling: negative signed values convert their magnitude
	assign negative = in_ch.mode && in_ch.value[i2d_pkg::VALUE_W-1];
	assign mag      = negative ? (i2d_pkg::VALUE_W'(0) - in_ch.value) : in_ch.value;

	i2d_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mag       (mag),
		.negative  (negative),
		.idle      (conv_idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	i2d_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.out_ch    (out_ch)
	);

endmodule
`default_nettype wire
